[hdl/jmsp_pkg.sv]
// Package for the JPEG marker segment parser.
// Holds marker codes, parse phases, status codes and the result record.
// No dependencies.
package jmsp_pkg;

	localparam logic [7:0] MarkerPrefix = 8'hFF;
	localparam logic [7:0] MarkerSoi    = 8'hD8;
	localparam logic [7:0] MarkerEoi    = 8'hD9;
	localparam logic [7:0] MarkerSos    = 8'hDA;
	localparam logic [7:0] MarkerDht    = 8'hC4;
	localparam logic [3:0] SofNibble    = 4'hC;

	typedef enum logic [2:0] {
		PH_PREFIX  = 3'd0,
		PH_CODE    = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_SCAN    = 3'd5
	} jmsp_phase_t;

	typedef enum logic [2:0] {
		ST_EOI     = 3'd0,
		ST_TRUNC   = 3'd1,
		ST_NO_FF   = 3'd2,
		ST_ZERO_H  = 3'd3,
		ST_BAD_LEN = 3'd4
	} jmsp_status_t;

	typedef struct packed {
		logic         parse_ok;
		logic [15:0]  image_width;
		logic [15:0]  image_height;
		jmsp_status_t status;
	} jmsp_result_t;

endpackage

[hdl/jpeg_marker_segment_parser.sv]
// Top level of the JPEG marker segment parser.
// Instantiates jmsp_parser and jmsp_out_buf; depends on jmsp_pkg.
//
// Usage:
//   Input channel: one stream byte per transaction on data_byte, with
//   last_byte high on the final byte of a stream. A transaction completes
//   on a rising edge with in_valid high and in_stall low.
//   Output channel: one result per stream (parse_ok, image_width,
//   image_height, status), a transaction on out_valid high and out_stall low.
//   Throughput: one byte per cycle while in_stall is low; the marker state
//   machine takes each byte as it comes and has no internal loop.
//   A result, set by the byte that settles it (EOI, error, or the last byte
//   of a truncated stream), is registered into the buffer for out_valid.
//   Stall: results go into a two-entry buffer. While the receiver stalls,
//   bytes keep being taken; in_stall rises only once both entries hold a
//   result, and falls when the receiver takes one.
//   Reset: arst_n clears the parser to the marker-prefix phase with zero
//   width and height, and empties the result buffer. The byte that carries
//   last_byte also returns the parser to that state for the next stream.
module jpeg_marker_segment_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        parse_ok,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [2:0]  status
);
	import jmsp_pkg::*;

	logic         accept;
	logic         res_valid;
	logic         buf_full;
	jmsp_result_t res;
	jmsp_result_t out_res;

	// take a byte whenever the buffer has room for a possible result
	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	jmsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	jmsp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	// unpack the held result onto the output ports
	assign parse_ok     = out_res.parse_ok;
	assign image_width  = out_res.image_width;
	assign image_height = out_res.image_height;
	assign status       = 3'(out_res.status);

endmodule

[hdl/jmsp_parser.sv]
// Byte-wide marker segment state machine of the JPEG marker segment parser.
// One byte per cycle while accept is high; emits at most one result per accepted byte.
// Depends on jmsp_pkg.
module jmsp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output logic                  res_valid,
	output jmsp_pkg::jmsp_result_t res
);
	import jmsp_pkg::*;

	jmsp_phase_t phase_q, phase_n;
	logic [15:0] seg_rem_q, seg_rem_n;
	logic [2:0]  seg_off_q, seg_off_n;
	logic        in_sof_q, in_sof_n;
	logic        prev_ff_q, prev_ff_n;
	logic [15:0] width_q, width_n;
	logic [15:0] height_q, height_n;
	logic        done_q, done_n;
	logic [7:0]  hold_q, hold_n;
	logic [15:0] seg_len;
	logic        have;
	jmsp_status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PREFIX;
			seg_rem_q <= '0;
			seg_off_q <= '0;
			in_sof_q  <= 1'b0;
			prev_ff_q <= 1'b0;
			width_q   <= '0;
			height_q  <= '0;
			done_q    <= 1'b0;
			hold_q    <= '0;
		end else if (accept) begin
			phase_q   <= phase_n;
			seg_rem_q <= seg_rem_n;
			seg_off_q <= seg_off_n;
			in_sof_q  <= in_sof_n;
			prev_ff_q <= prev_ff_n;
			width_q   <= width_n;
			height_q  <= height_n;
			done_q    <= done_n;
			hold_q    <= hold_n;
		end
	end

	assign seg_len = {seg_rem_q[7:0], data_byte};

	always_comb begin
		phase_n   = phase_q;
		seg_rem_n = seg_rem_q;
		seg_off_n = seg_off_q;
		in_sof_n  = in_sof_q;
		prev_ff_n = prev_ff_q;
		width_n   = width_q;
		height_n  = height_q;
		done_n    = done_q;
		hold_n    = hold_q;
		have      = 1'b0;
		st        = ST_TRUNC;

		if (!done_q) begin
			case (phase_q)
				PH_PREFIX: begin
					if (data_byte == MarkerPrefix) begin
						phase_n = PH_CODE;
					end else begin
						have = 1'b1;
						st   = ST_NO_FF;
					end
				end
				PH_CODE: begin
					if (data_byte == MarkerPrefix) begin
						phase_n = PH_CODE;
					end else if (data_byte == MarkerSoi) begin
						phase_n = PH_PREFIX;
					end else if (data_byte == MarkerEoi) begin
						have = 1'b1;
						st   = ST_EOI;
					end else if (data_byte == MarkerSos) begin
						phase_n   = PH_SCAN;
						prev_ff_n = 1'b0;
					end else begin
						in_sof_n = (data_byte[7:4] == SofNibble) && (data_byte != MarkerDht);
						phase_n  = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					seg_rem_n = {8'd0, data_byte};
					phase_n   = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (seg_len < 16'd2 || (in_sof_q && seg_len < 16'd7)) begin
						have = 1'b1;
						st   = ST_BAD_LEN;
					end else begin
						seg_rem_n = seg_len - 16'd2;
						seg_off_n = 3'd2;
						phase_n   = (seg_rem_n != 16'd0) ? PH_PAYLOAD : PH_PREFIX;
					end
				end
				PH_PAYLOAD: begin
					if (in_sof_q) begin
						if (seg_off_q inside {3'd3, 3'd5}) begin
							hold_n = data_byte;
						end else if (seg_off_q == 3'd4) begin
							height_n = {hold_q, data_byte};
						end else if (seg_off_q == 3'd6) begin
							width_n = {hold_q, data_byte};
							if (height_q == 16'd0) begin
								have = 1'b1;
								st   = ST_ZERO_H;
							end
						end
					end
					if (seg_off_q != 3'd7) begin
						seg_off_n = seg_off_q + 3'd1;
					end
					seg_rem_n = seg_rem_q - 16'd1;
					if (seg_rem_n == 16'd0) begin
						phase_n = PH_PREFIX;
					end
				end
				PH_SCAN: begin
					if (prev_ff_q && data_byte == MarkerEoi) begin
						have = 1'b1;
						st   = ST_EOI;
					end
					prev_ff_n = (data_byte == MarkerPrefix);
				end
				default: begin
					phase_n = PH_PREFIX;
				end
			endcase

			if (!have && last_byte) begin
				have = 1'b1;
				st   = ST_TRUNC;
			end
			if (have) begin
				done_n = 1'b1;
			end
		end

		res.parse_ok     = (st == ST_EOI);
		res.image_width  = width_n;
		res.image_height = height_n;
		res.status       = st;
		res_valid        = accept && have;

		// end of stream: back to reset state for the next one
		if (last_byte) begin
			phase_n   = PH_PREFIX;
			seg_rem_n = '0;
			seg_off_n = '0;
			in_sof_n  = 1'b0;
			prev_ff_n = 1'b0;
			width_n   = '0;
			height_n  = '0;
			done_n    = 1'b0;
			hold_n    = '0;
		end
	end

endmodule

[hdl/jmsp_out_buf.sv]
// Two-entry result buffer (output register plus skid entry).
// Keeps the input side free while a result waits on a stalled receiver.
// Depends on jmsp_pkg.
module jmsp_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  jmsp_pkg::jmsp_result_t push_data,
	output logic                   full,
	output logic                   out_valid,
	input  logic                   out_stall,
	output jmsp_pkg::jmsp_result_t out_data
);
	import jmsp_pkg::*;

	logic         main_valid_q, skid_valid_q;
	jmsp_result_t main_q, skid_q;
	logic         pop;

	assign pop       = main_valid_q && !out_stall;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without output entry");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(main_valid_q && out_stall && push))
		else $error("skid entry filled without a stalled output");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("result pushed into full buffer");

endmodule
